>>> rtl/core/pip_pkg.sv
// Shared constants, codes and control structs for the point-in-polygon test core.
package pip_pkg;

    // Fixed field and register widths
    localparam int SLOT_W      = 6;
    localparam int SIDE_CNT_W  = 7;
    localparam int M_TDATA_W   = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Defaults for the top-level parameters
    localparam int MAX_SIDES_DEF = 64;
    localparam int COORD_W_DEF   = 16;

    // Register index, taken from paddr above the byte lanes
    localparam logic [APB_ADDR_W-3:0] REG_IDX_SIDE_COUNT = '0;

    // Operation carried in tuser
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Sequencer to edge unit
    typedef struct packed {
        logic clear;      // start of a query: drop the inside flag
        logic vtx_valid;  // a vertex from the store is on vtx_x / vtx_y
        logic prime;      // this vertex only seeds the previous-vertex register
    } edge_ctrl_t;

    // Edge unit to sequencer
    typedef struct packed {
        logic busy;       // edges still in flight
        logic in_poly;    // even-odd flag so far
    } edge_stat_t;

endpackage

>>> rtl/core/pip_vertex_mem.sv
// Vertex store: one write port, one read port with registered read data.
module pip_vertex_mem #(
    parameter int DEPTH  = pip_pkg::MAX_SIDES_DEF,
    parameter int DATA_W = 2 * pip_pkg::COORD_W_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write a vertex
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read a vertex into the registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/pip_edge_unit.sv
// Shared edge unit: one polygon side per cycle, pipelined crossing test and even-odd toggle.
module pip_edge_unit #(
    parameter int COORD_W = pip_pkg::COORD_W_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pip_pkg::edge_ctrl_t       ctrl,
    input  logic signed [COORD_W-1:0] vtx_x,
    input  logic signed [COORD_W-1:0] vtx_y,
    input  logic signed [COORD_W-1:0] pt_x,
    input  logic signed [COORD_W-1:0] pt_y,
    output pip_pkg::edge_stat_t       stat
);

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    // Previous vertex (j end of the side)
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;

    // Stage 0, combinational: differences and straddle test
    logic signed [DW-1:0] dyi_c;
    logic signed [DW-1:0] dxi_c;
    logic signed [DW-1:0] dxj_c;
    logic signed [DW-1:0] dyj_c;
    logic                 straddle_c;
    logic                 near_c;

    // Stage 1 registers
    logic                 valid1_reg;
    logic                 count1_reg;
    logic signed [DW-1:0] dyi1_reg;
    logic signed [DW-1:0] dxi1_reg;
    logic signed [DW-1:0] dxj1_reg;
    logic signed [DW-1:0] dyj1_reg;

    // Stage 2 registers
    logic                 valid2_reg;
    logic                 count2_reg;
    logic                 dypos2_reg;
    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;

    logic left_c;
    logic inside_reg;

    assign dyi_c = $signed({pt_y[COORD_W-1], pt_y}) - $signed({vtx_y[COORD_W-1], vtx_y});
    assign dxi_c = $signed({pt_x[COORD_W-1], pt_x}) - $signed({vtx_x[COORD_W-1], vtx_x});
    assign dxj_c = $signed({prev_x_reg[COORD_W-1], prev_x_reg})
                 - $signed({vtx_x[COORD_W-1], vtx_x});
    assign dyj_c = $signed({prev_y_reg[COORD_W-1], prev_y_reg})
                 - $signed({vtx_y[COORD_W-1], vtx_y});

    assign straddle_c = ((vtx_y < pt_y) && (prev_y_reg >= pt_y))
                     || ((prev_y_reg < pt_y) && (vtx_y >= pt_y));
    assign near_c     = (vtx_x <= pt_x) || (prev_x_reg <= pt_x);

    // Hold the last vertex seen as the j end of the next side
    always_ff @(posedge aclk) begin
        if (ctrl.vtx_valid) begin
            prev_x_reg <= vtx_x;
            prev_y_reg <= vtx_y;
        end
    end

    // Stage 1: register differences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else begin
            valid1_reg <= ctrl.vtx_valid && !ctrl.prime;
        end
        count1_reg <= straddle_c && near_c;
        dyi1_reg   <= dyi_c;
        dxi1_reg   <= dxi_c;
        dxj1_reg   <= dxj_c;
        dyj1_reg   <= dyj_c;
    end

    // Stage 2: both cross products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else begin
            valid2_reg <= valid1_reg;
        end
        count2_reg <= count1_reg;
        dypos2_reg <= !dyj1_reg[DW-1];
        prod_a_reg <= dyi1_reg * dxj1_reg;
        prod_b_reg <= dxi1_reg * dyj1_reg;
    end

    // Stage 3: compare, with the order flipped by the sign of the y span
    assign left_c = dypos2_reg ? (prod_a_reg < prod_b_reg) : (prod_b_reg < prod_a_reg);

    // Toggle the even-odd flag on a crossing left of the point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
        end else if (ctrl.clear) begin
            inside_reg <= 1'b0;
        end else if (valid2_reg && count2_reg && left_c) begin
            inside_reg <= !inside_reg;
        end
    end

    assign stat.busy    = valid1_reg || valid2_reg;
    assign stat.in_poly = inside_reg;

endmodule

>>> rtl/core/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test core: ports, sequencer, config register.
//
//   channel   | direction | beat contents
//   ----------+-----------+--------------------------------------------------
//   s_axis    | in        | tuser: operation; tdata: vertex_slot, coord_x, coord_y
//   m_axis    | out       | tdata: inside_res, one beat per query
//   apb       | in        | side_count at byte address 0
//
// A load leaves s_axis_tready high. A query over n sides (n = side_count, capped at
// MAX_SIDES) holds s_axis_tready low until its result is loaded: n + 1 reads of the
// vertex store, a drain of the last read and the edge pipeline, then the load of the
// result into the output register. With no sides, no reads and no drain.
// A full output register holds the sequencer until the result beat is taken.
// Reset is synchronous; it clears the sequencer and side_count, not the store.
module point_in_polygon_test_core #(
    parameter int MAX_SIDES = pip_pkg::MAX_SIDES_DEF,
    parameter int COORD_W   = pip_pkg::COORD_W_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: vertex_slot, coord_x, coord_y (lowest bits first), zero padded
    input  logic [((pip_pkg::SLOT_W + 2 * COORD_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: operation
    input  logic [0:0]                      s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: inside_res in bit 0, zero padded
    output logic [pip_pkg::M_TDATA_W-1:0]   m_axis_tdata,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pip_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pip_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pip_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int AW    = $clog2(MAX_SIDES);
    localparam int CNT_W = $clog2(MAX_SIDES + 1);
    localparam int SW    = pip_pkg::SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [pip_pkg::SIDE_CNT_W-1:0] side_count_reg;
    logic [CNT_W-1:0]               n_reg;
    logic [CNT_W-1:0]               rd_cnt_reg;
    logic signed [COORD_W-1:0]      px_reg;
    logic signed [COORD_W-1:0]      py_reg;
    logic                           m_valid_reg;
    logic                           m_inside_reg;
    logic                           mem_valid_reg;
    logic                           mem_prime_reg;

    logic                           in_beat;
    logic                           is_query;
    logic [SW-1:0]                  in_slot;
    logic signed [COORD_W-1:0]      in_x;
    logic signed [COORD_W-1:0]      in_y;
    logic [CNT_W-1:0]               n_clamp;
    logic                           cfg_hit;

    logic                           wr_en;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [2*COORD_W-1:0]           rd_data;

    pip_pkg::edge_ctrl_t            ctrl;
    pip_pkg::edge_stat_t            stat;

    // Unpack the input beat
    assign in_slot  = s_axis_tdata[SW-1:0];
    assign in_x     = s_axis_tdata[SW +: COORD_W];
    assign in_y     = s_axis_tdata[SW + COORD_W +: COORD_W];
    assign is_query = (s_axis_tuser[0] == pip_pkg::OP_QUERY);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Side count, capped at the store depth
    assign n_clamp = (32'(side_count_reg) > MAX_SIDES) ? CNT_W'(MAX_SIDES)
                                                       : CNT_W'(side_count_reg);

    // Config port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[pip_pkg::APB_ADDR_W-1:2] == pip_pkg::REG_IDX_SIDE_COUNT);
    assign prdata  = cfg_hit ? pip_pkg::APB_DATA_W'(side_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_count_reg <= '0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            side_count_reg <= pwdata[pip_pkg::SIDE_CNT_W-1:0];
        end
    end

    // Vertex loads; slots past the store are dropped
    assign wr_en = in_beat && !is_query && (32'(in_slot) < MAX_SIDES);

    // Read order: last vertex first to seed the closing side, then 0 .. n-1
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = (rd_cnt_reg == '0) ? AW'(n_reg - CNT_W'(1))
                                        : AW'(rd_cnt_reg - CNT_W'(1));

    pip_vertex_mem #(
        .DEPTH  (MAX_SIDES),
        .DATA_W (2 * COORD_W)
    ) u_pip_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_slot)),
        .wr_data ({in_y, in_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ctrl.clear     = in_beat && is_query;
    assign ctrl.vtx_valid = mem_valid_reg;
    assign ctrl.prime     = mem_prime_reg;

    pip_edge_unit #(
        .COORD_W (COORD_W)
    ) u_pip_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .vtx_x   (rd_data[COORD_W-1:0]),
        .vtx_y   (rd_data[2*COORD_W-1:COORD_W]),
        .pt_x    (px_reg),
        .pt_y    (py_reg),
        .stat    (stat)
    );

    // Sequencer, read-data tags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
            mem_valid_reg <= 1'b0;
            mem_prime_reg <= 1'b0;
        end else begin
            mem_valid_reg <= rd_en;
            mem_prime_reg <= rd_en && (rd_cnt_reg == '0);
            // Drop a taken result beat; the finish state reloads it itself
            if (m_valid_reg && m_axis_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat && is_query) begin
                        px_reg     <= in_x;
                        py_reg     <= in_y;
                        n_reg      <= n_clamp;
                        rd_cnt_reg <= '0;
                        state_reg  <= (n_clamp == '0) ? ST_FINISH : ST_READ;
                    end
                end
                ST_READ: begin
                    if (rd_cnt_reg == n_reg) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!mem_valid_reg && !stat.busy) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // Load the result once the output register is free
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_inside_reg <= stat.in_poly;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = pip_pkg::M_TDATA_W'(m_inside_reg);

endmodule

>>> rtl/core/pip_checker.sv
// Port-level checker for the point-in-polygon test core, bound to the top level.
module pip_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [0:0]                    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pip_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed or dropped while stalled");

    // A query occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == pip_pkg::OP_QUERY)
        |=> !s_axis_tready)
        else $error("ready stayed high after a query beat");

    // A vertex load leaves the block ready for the next beat
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == pip_pkg::OP_LOAD)
        |=> s_axis_tready)
        else $error("ready dropped after a load beat");

    // Only bit 0 of a result beat carries data
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[pip_pkg::M_TDATA_W-1:1] == '0))
        else $error("padding bits of result beat are not zero");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

>>> tb/tb.sv
// Testbench for the point-in-polygon test core: vertex loads, point queries, side count.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIDES   = pip_pkg::MAX_SIDES_DEF;
    localparam int COORD_W     = pip_pkg::COORD_W_DEF;
    localparam int SLOT_W      = pip_pkg::SLOT_W;
    localparam int M_TDATA_W   = pip_pkg::M_TDATA_W;
    localparam int APB_ADDR_W  = pip_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = pip_pkg::APB_DATA_W;
    localparam int S_TDATA_W   = ((SLOT_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int RAND_BEATS  = 800;
    localparam int IDLE_PCT    = 14;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [APB_ADDR_W-1:0] SIDE_COUNT_ADDR = {pip_pkg::REG_IDX_SIDE_COUNT, 2'b00};

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [S_TDATA_W-1:0]        s_axis_tdata  = '0;
    logic [0:0]                  s_axis_tuser  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]        m_axis_tdata;
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr         = '0;
    logic [APB_DATA_W-1:0]       pwdata        = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    // Mirror of the block: vertex store, side count, pending inside flags
    logic signed [COORD_W-1:0]   poly_x [MAX_SIDES];
    logic signed [COORD_W-1:0]   poly_y [MAX_SIDES];
    int unsigned                 side_cnt;
    bit                          in_poly_q [$];

    bit                          calm;
    bit                          want_flag;
    int                          err_cnt;
    int                          beat_cnt;
    int                          load_cnt;
    int                          query_cnt;
    int                          flag_cnt;
    int                          flag_set_cnt;
    int                          setting_cnt;
    int                          cycle_cnt;

    point_in_polygon_test_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result channel at random unless in a calm stretch
    always @(posedge aclk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each result beat against the oldest pending flag
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (in_poly_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got inside_res %0b",
                         $time, m_axis_tdata[0]);
                err_cnt++;
            end else begin
                want_flag = in_poly_q.pop_front();
                flag_cnt++;
                if (want_flag) flag_set_cnt++;
                if (m_axis_tdata[0] !== want_flag) begin
                    $display("%0t: inside_res mismatch, expected %0b, got %0b",
                             $time, want_flag, m_axis_tdata[0]);
                    err_cnt++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, in_poly_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Even-odd crossing count over the sides in use, exact integer compare
    function automatic bit point_in_poly(longint px, longint py);
        int      n;
        int      j;
        bit      flag;
        longint  xi, yi, xj, yj, dy, lhs, rhs;
        n    = (side_cnt > MAX_SIDES) ? MAX_SIDES : side_cnt;
        flag = 1'b0;
        j    = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if (((yi < py) && (yj >= py)) || ((yj < py) && (yi >= py))) begin
                if ((xi <= px) || (xj <= px)) begin
                    dy  = yj - yi;
                    lhs = (py - yi) * (xj - xi);
                    rhs = (px - xi) * dy;
                    // the sign of dy flips the sense of the compare
                    if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) flag = ~flag;
                end
            end
            j = i;
        end
        return flag;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(int span);
        if (span >= 32767) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    // Drive one input beat, wait for the handshake, update the mirror
    task automatic send_beat(pip_pkg::op_t op, logic [SLOT_W-1:0] slot,
                             logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        if (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tdata <= S_TDATA_W'({y, x, slot});
        s_axis_tuser <= op;
        if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        beat_cnt++;
        if (op == pip_pkg::OP_LOAD) begin
            poly_x[slot] = x;
            poly_y[slot] = y;
            load_cnt++;
        end else begin
            in_poly_q.push_back(point_in_poly(x, y));
            query_cnt++;
        end
    endtask

    task automatic load_vertex(int slot, logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y);
        send_beat(pip_pkg::OP_LOAD, SLOT_W'(slot), x, y);
    endtask

    task automatic query_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        send_beat(pip_pkg::OP_QUERY, '0, x, y);
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle_block(int quiet_cycles);
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (in_poly_q.size() != 0) @(posedge aclk);
        repeat (quiet_cycles) @(posedge aclk);
    endtask

    // Write side_count over APB, then read it back
    task automatic set_side_count(int unsigned n);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIDE_COUNT_ADDR;
        pwdata  <= APB_DATA_W'(n);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        side_cnt = n;
        setting_cnt++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_W'(n)) begin
            $display("%0t: side_count readback mismatch, expected %0d, got %0d",
                     $time, n, prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One polygon: set the count, load every vertex, then query points around it
    task automatic run_polygon(int n, int span, int n_queries);
        int                        first;
        int                        k;
        logic signed [COORD_W-1:0] qx, qy;
        settle_block(8);
        set_side_count(n);
        first = (n > 0) ? $urandom_range(n - 1) : 0;
        for (int v = 0; v < n; v++) begin
            load_vertex((first + v) % n, rand_coord(span), rand_coord(span));
        end
        for (int q = 0; q < n_queries; q++) begin
            // stray loads anywhere in the store, polygon included
            if ($urandom_range(99) < 15) begin
                load_vertex($urandom_range(MAX_SIDES - 1), rand_coord(span), rand_coord(span));
            end
            k = (n > 0) ? $urandom_range(n - 1) : 0;
            case ((n > 0) ? $urandom_range(4) : 3)
                0: begin
                    qx = poly_x[k];
                    qy = poly_y[k];
                end
                1: begin
                    qx = rand_coord(span);
                    qy = poly_y[k];
                end
                2: begin
                    qx = COORD_W'(poly_x[k] + COORD_W'($urandom_range(2)) - 1);
                    qy = COORD_W'(poly_y[k] + COORD_W'($urandom_range(2)) - 1);
                end
                3: begin
                    qx = rand_coord(span);
                    qy = rand_coord(span);
                end
                default: begin
                    qx = rand_coord(32767);
                    qy = rand_coord(32767);
                end
            endcase
            query_point(qx, qy);
        end
    endtask

    // No sides: always outside, and the store is never read
    task automatic test_empty_polygon();
        set_side_count(0);
        query_point(16'sh8000, 16'sh8000);
        query_point(16'sh7FFF, 16'sh7FFF);
    endtask

    // Square on the coordinate extremes, points on corners, edges and center
    task automatic test_extreme_square();
        settle_block(8);
        set_side_count(4);
        load_vertex(0, 16'sh8000, 16'sh8000);
        load_vertex(1, 16'sh7FFF, 16'sh8000);
        load_vertex(2, 16'sh7FFF, 16'sh7FFF);
        load_vertex(3, 16'sh8000, 16'sh7FFF);
        query_point(16'sh0000, 16'sh0000);
        query_point(16'sh8000, 16'sh8000);
        query_point(16'sh7FFF, 16'sh7FFF);
        query_point(16'sh8000, 16'sh0000);
        query_point(16'sh7FFF, 16'sh0001);
    endtask

    // One and two sides, then a small triangle full of ties
    task automatic test_degenerate_polygons();
        settle_block(8);
        set_side_count(1);
        query_point(16'sh0000, 16'sh0000);
        settle_block(8);
        set_side_count(2);
        load_vertex(1, 16'sh7FFF, 16'sh7FFF);
        query_point(16'sh0000, 16'sh0000);
        query_point(16'sh7FFF, 16'sh0000);
        settle_block(8);
        set_side_count(3);
        load_vertex(0, 16'sd0, 16'sd0);
        load_vertex(1, 16'sd10, 16'sd0);
        load_vertex(2, 16'sd0, 16'sd10);
        query_point(16'sd0, 16'sd0);
        query_point(16'sd5, 16'sd0);
        query_point(16'sd5, 16'sd5);
        query_point(16'sd1, 16'sd1);
        query_point(16'sd0, 16'sd5);
    endtask

    // Every slot in use, wide and cramped coordinates
    task automatic test_full_store();
        run_polygon(MAX_SIDES, 32767, 10);
        run_polygon(MAX_SIDES, 6, 6);
    endtask

    // No input gaps and no result stalls for one whole polygon
    task automatic test_back_to_back();
        settle_block(8);
        calm = 1'b1;
        run_polygon(16, 300, 30);
        settle_block(8);
        calm = 1'b0;
    endtask

    // Random polygons: mostly small, a few empty, degenerate or large
    task automatic test_random_polygons();
        int start;
        int pick;
        int n;
        int span;
        start = beat_cnt;
        while (beat_cnt - start < RAND_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 3)       n = 0;
            else if (pick < 8)  n = $urandom_range(1, 2);
            else if (pick < 14) n = $urandom_range(33, MAX_SIDES);
            else                n = $urandom_range(3, 12);
            case ($urandom_range(2))
                0:       span = 6;
                1:       span = 300;
                default: span = 32767;
            endcase
            run_polygon(n, span, $urandom_range(4, 14));
        end
    endtask

    initial begin
        calm = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_polygon();
        test_extreme_square();
        test_degenerate_polygons();
        test_full_store();
        test_back_to_back();
        test_random_polygons();

        settle_block(80);
        $display("Covered %0d vertex loads and %0d point queries over %0d side_count writes.",
                 load_cnt, query_cnt, setting_cnt);
        $display("Checked %0d inside_res beats (%0d inside), %0d mismatches.",
                 flag_cnt, flag_set_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
